### rtl/core/eqh_pkg.sv
// Shared widths, fixed-point constants and elaboration-time CORDIC table functions.
`default_nettype none
package eqh_pkg;

  // fraction bits of sines, cosines and vector components
  localparam int VFRAC = 30;
  // rotation datapath width (unit vectors with margin)
  localparam int ROT_W = 34;
  // vectoring datapath width (gain growth with margin)
  localparam int VEC_W = 36;
  // 2^64 / (2*pi)
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic signed [ROT_W-1:0] VONE = ROT_W'(64'd1 << VFRAC);

  // unsigned restoring division, used for constants only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // integer square root, used for constants only
  function automatic logic [63:0] isqrt64(logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    n   = n_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int t = 0; t < 32; t++) begin
      if (bt > n) bt = bt >> 2;
    end
    for (int t = 0; t < 32; t++) begin
      if (bt != 0) begin
        if (n >= res + bt) begin
          n   = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // atan(2^-i) in units of 2^ab per full turn, rounded to nearest
  function automatic logic [63:0] atan_unit(int ab, int i);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [63:0]  turn;
    logic [127:0] p;
    int           e;
    int           sh;
    if (i == 0) return 64'd1 << (ab - 3);
    rad = '0;
    for (int k = 0; k < 63; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = udiv64(64'd1 << e, 64'(2 * k + 1));
        if (k % 2 == 1) rad = rad - term;
        else rad = rad + term;
      end
    end
    p    = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
    turn = p[127:64];
    sh   = 62 - ab;
    return (turn + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // inverse CORDIC gain in Q30, truncated
  function automatic logic [63:0] inv_gain(int ns);
    logic [63:0] prod;
    prod = 64'd1 << 60;
    for (int i = 0; i < ns; i++) begin
      if (2 * i < 64) prod = prod + (prod >> (2 * i));
    end
    return udiv64(64'd1 << 60, isqrt64(prod));
  endfunction

endpackage
`default_nettype wire

### rtl/core/equatorial_to_horizontal_top.sv
// Top level: equatorial to horizontal coordinate conversion pipeline.
// Usage:
//   Configuration: write observer latitude (index 0) and longitude (index 1)
//   through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only
//   while no item is in flight.
//   Input: an item (declination, right ascension, sidereal time, binary angles
//   with 2^31 = pi) is taken at each clock edge with start high; busy stays low.
//   Output: out_strobe marks one cycle carrying azimuth and altitude.
//   Throughput: one item per cycle; every CORDIC iteration and each multiply
//   has its own register stage, so the sine/cosine lanes, the product stages
//   and the two vectoring pipelines all run concurrently.
//   Reset: synchronous, active low; clears all valid bits in flight and sets
//   both observer registers to zero.
//   The receiver cannot stall; results leave the pipeline as they complete.
`default_nettype none
module equatorial_to_horizontal_top #(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 30
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_star_declination,
  input  wire logic signed [31:0] in_star_right_ascension,
  input  wire logic signed [31:0] in_sidereal_time,
  output logic                    out_strobe,
  output logic signed [31:0]      out_azimuth_angle,
  output logic signed [31:0]      out_altitude_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import eqh_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int NS = CORDIC_STAGES;
  localparam logic CFG_LATITUDE  = 1'b0;
  localparam logic CFG_LONGITUDE = 1'b1;
  localparam logic signed [ROT_W-1:0] INV_G = ROT_W'(inv_gain(NS));

  // convert a 32-bit binary angle to the internal width
  function automatic logic [AB-1:0] ang_in(logic [31:0] v);
    logic signed [63:0] s;
    s = 64'(signed'(v));
    if (AB >= 32) return AB'(s <<< (AB >= 32 ? AB - 32 : 0));
    return AB'(s >>> (AB < 32 ? 32 - AB : 0));
  endfunction

  // convert an internal angle back to 32 bits, rounding half up
  function automatic logic [31:0] ang_out(logic [AB-1:0] v);
    logic signed [63:0] a;
    a = 64'(signed'(v));
    if (AB > 32) return 32'((a + (64'sd1 <<< (AB > 32 ? AB - 33 : 0))) >>> (AB > 32 ? AB - 32 : 0));
    return 32'(a <<< (AB <= 32 ? 32 - AB : 0));
  endfunction

  logic [31:0] lat_r;
  logic [31:0] lon_r;

  // hold observer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '0;
      lon_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LATITUDE:  lat_r <= cfg_data;
        CFG_LONGITUDE: lon_r <= cfg_data;
        default:       lat_r <= lat_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // form hour angle and internal angles
  logic                 s0_vld_r;
  logic signed [AB-1:0] s0_ang_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    s0_ang_r[0] <= ang_in(in_star_declination);
    s0_ang_r[1] <= ang_in(lat_r);
    s0_ang_r[2] <= ang_in(in_sidereal_time) - ang_in(lon_r) - ang_in(in_star_right_ascension);
  end

  logic                    rot_vld;
  logic signed [ROT_W-1:0] rot_cos [0:2];
  logic signed [ROT_W-1:0] rot_sin [0:2];

  eqh_rotate #(.AB(AB), .NS(NS)) u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_vld_r),
    .ang_i   (s0_ang_r),
    .out_vld (rot_vld),
    .cos_o   (rot_cos),
    .sin_o   (rot_sin)
  );

  // lane order: declination, latitude, hour angle
  logic signed [ROT_W-1:0] cd, sd, cl, sl, ch, sh;
  assign cd = rot_cos[0];
  assign sd = rot_sin[0];
  assign cl = rot_cos[1];
  assign sl = rot_sin[1];
  assign ch = rot_cos[2];
  assign sh = rot_sin[2];

  function automatic logic signed [ROT_W-1:0] mul_q(logic signed [ROT_W-1:0] a,
                                                     logic signed [ROT_W-1:0] b);
    logic signed [2*ROT_W-1:0] p;
    p = a * b;
    return ROT_W'(p >>> VFRAC);
  endfunction

  // first products
  logic                    p1_vld_r;
  logic signed [ROT_W-1:0] p1_y_r, p1_chcd_r, p1_sdcl_r, p1_slsd_r, p1_clcd_r, p1_sl_r, p1_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= rot_vld;
    end
    p1_y_r    <= mul_q(sh, cd);
    p1_chcd_r <= mul_q(ch, cd);
    p1_sdcl_r <= mul_q(sd, cl);
    p1_slsd_r <= mul_q(sl, sd);
    p1_clcd_r <= mul_q(cl, cd);
    p1_sl_r   <= sl;
    p1_ch_r   <= ch;
  end

  // second products
  logic                    p2_vld_r;
  logic signed [ROT_W-1:0] p2_y_r, p2_a_r, p2_sdcl_r, p2_slsd_r, p2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_y_r    <= p1_y_r;
    p2_a_r    <= mul_q(p1_chcd_r, p1_sl_r);
    p2_sdcl_r <= p1_sdcl_r;
    p2_slsd_r <= p1_slsd_r;
    p2_b_r    <= mul_q(p1_clcd_r, p1_ch_r);
  end

  // sums into vector components
  logic                    p3_vld_r;
  logic signed [VEC_W-1:0] p3_x_r, p3_y_r, p3_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
    p3_x_r <= VEC_W'(p2_a_r) - VEC_W'(p2_sdcl_r);
    p3_y_r <= VEC_W'(p2_y_r);
    p3_z_r <= VEC_W'(p2_slsd_r) + VEC_W'(p2_b_r);
  end

  // delay z alongside the azimuth vectoring
  logic signed [VEC_W-1:0] z_dly_r [0:NS];

  always_ff @(posedge clk) begin
    z_dly_r[0] <= p3_z_r;
    for (int k = 1; k <= NS; k++) z_dly_r[k] <= z_dly_r[k-1];
  end

  logic                    v1_vld;
  logic signed [AB-1:0]    v1_ang;
  logic signed [VEC_W-1:0] v1_mag;

  eqh_vector #(.AB(AB), .NS(NS)) u_vec_az (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p3_vld_r),
    .x_i     (p3_x_r),
    .y_i     (p3_y_r),
    .out_vld (v1_vld),
    .ang_o   (v1_ang),
    .mag_o   (v1_mag)
  );

  // remove the CORDIC gain from the magnitude
  logic                          g_vld_r;
  logic signed [VEC_W-1:0]       g_r_r, g_z_r;
  logic signed [AB-1:0]          g_az_r;
  logic signed [VEC_W+ROT_W-1:0] g_prod;

  assign g_prod = v1_mag * INV_G;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= v1_vld;
    end
    g_r_r  <= VEC_W'(g_prod >>> VFRAC);
    g_z_r  <= z_dly_r[NS];
    g_az_r <= v1_ang;
  end

  // delay azimuth alongside the altitude vectoring
  logic signed [AB-1:0] az_dly_r [0:NS];

  always_ff @(posedge clk) begin
    az_dly_r[0] <= g_az_r;
    for (int k = 1; k <= NS; k++) az_dly_r[k] <= az_dly_r[k-1];
  end

  logic                 v2_vld;
  logic signed [AB-1:0] v2_ang;

  eqh_vector #(.AB(AB), .NS(NS)) u_vec_alt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (g_vld_r),
    .x_i     (g_r_r),
    .y_i     (g_z_r),
    .out_vld (v2_vld),
    .ang_o   (v2_ang),
    .mag_o   ()
  );

  // register results for one strobe cycle
  logic        out_strobe_r;
  logic [31:0] out_az_r, out_alt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v2_vld;
    end
    out_az_r  <= ang_out(az_dly_r[NS]);
    out_alt_r <= ang_out(v2_ang);
  end

  assign out_strobe         = out_strobe_r;
  assign out_azimuth_angle  = out_az_r;
  assign out_altitude_angle = out_alt_r;

endmodule
`default_nettype wire

### rtl/core/eqh_rotate.sv
// Three-lane pipelined rotation CORDIC giving cosine and sine of each angle.
`default_nettype none
module eqh_rotate #(
  parameter int AB = 32,
  parameter int NS = 30
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_vld,
  input  wire logic signed [AB-1:0]            ang_i [0:2],
  output logic                                 out_vld,
  output logic signed [eqh_pkg::ROT_W-1:0]     cos_o [0:2],
  output logic signed [eqh_pkg::ROT_W-1:0]     sin_o [0:2]
);
  import eqh_pkg::*;

  localparam logic signed [AB-1:0] QUARTER = AB'(64'd1 << (AB - 2));
  localparam logic signed [AB-1:0] HALF    = AB'(64'd1 << (AB - 1));
  localparam logic signed [ROT_W-1:0] X0   = ROT_W'(inv_gain(NS));

  logic                    vld_r  [0:NS];
  logic signed [ROT_W-1:0] x_r    [0:NS][0:2];
  logic signed [ROT_W-1:0] y_r    [0:NS][0:2];
  logic signed [AB-1:0]    a_r    [0:NS][0:2];
  logic                    flip_r [0:NS][0:2];
  logic                    spec_r [0:NS][0:2];
  logic                    pos_r  [0:NS][0:2];

  logic signed [AB-1:0]    a_nxt    [0:2];
  logic                    flip_nxt [0:2];
  logic                    spec_nxt [0:2];
  logic                    pos_nxt  [0:2];

  logic                    out_vld_r;
  logic signed [ROT_W-1:0] cos_r [0:2];
  logic signed [ROT_W-1:0] sin_r [0:2];

  // fold angles into the right half plane and flag exact quarter turns
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      spec_nxt[l] = (ang_i[l] == QUARTER) || (ang_i[l] == -QUARTER);
      pos_nxt[l]  = ang_i[l] > 0;
      priority if (ang_i[l] > QUARTER) begin
        a_nxt[l]    = ang_i[l] - HALF;
        flip_nxt[l] = 1'b1;
      end else if (ang_i[l] < -QUARTER) begin
        a_nxt[l]    = ang_i[l] + HALF;
        flip_nxt[l] = 1'b1;
      end else begin
        a_nxt[l]    = ang_i[l];
        flip_nxt[l] = 1'b0;
      end
    end
  end

  // load the first stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    for (int l = 0; l < 3; l++) begin
      x_r[0][l]    <= X0;
      y_r[0][l]    <= '0;
      a_r[0][l]    <= a_nxt[l];
      flip_r[0][l] <= flip_nxt[l];
      spec_r[0][l] <= spec_nxt[l];
      pos_r[0][l]  <= pos_nxt[l];
    end
  end

  // one micro-rotation per stage
  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam logic signed [AB-1:0] ATN = AB'(atan_unit(AB, k - 1));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      for (int l = 0; l < 3; l++) begin
        if (a_r[k-1][l] >= 0) begin
          x_r[k][l] <= x_r[k-1][l] - (y_r[k-1][l] >>> (k - 1));
          y_r[k][l] <= y_r[k-1][l] + (x_r[k-1][l] >>> (k - 1));
          a_r[k][l] <= a_r[k-1][l] - ATN;
        end else begin
          x_r[k][l] <= x_r[k-1][l] + (y_r[k-1][l] >>> (k - 1));
          y_r[k][l] <= y_r[k-1][l] - (x_r[k-1][l] >>> (k - 1));
          a_r[k][l] <= a_r[k-1][l] + ATN;
        end
        flip_r[k][l] <= flip_r[k-1][l];
        spec_r[k][l] <= spec_r[k-1][l];
        pos_r[k][l]  <= pos_r[k-1][l];
      end
    end
  end

  // undo the fold and apply exact quarter-turn values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[NS];
    end
    for (int l = 0; l < 3; l++) begin
      if (spec_r[NS][l]) begin
        cos_r[l] <= '0;
        sin_r[l] <= pos_r[NS][l] ? VONE : -VONE;
      end else if (flip_r[NS][l]) begin
        cos_r[l] <= -x_r[NS][l];
        sin_r[l] <= -y_r[NS][l];
      end else begin
        cos_r[l] <= x_r[NS][l];
        sin_r[l] <= y_r[NS][l];
      end
    end
  end

  assign out_vld = out_vld_r;
  assign cos_o   = cos_r;
  assign sin_o   = sin_r;

endmodule
`default_nettype wire

### rtl/core/eqh_vector.sv
// Pipelined vectoring CORDIC giving atan2(y, x) and the gain-scaled magnitude.
`default_nettype none
module eqh_vector #(
  parameter int AB = 32,
  parameter int NS = 30
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic signed [eqh_pkg::VEC_W-1:0] x_i,
  input  wire logic signed [eqh_pkg::VEC_W-1:0] y_i,
  output logic                             out_vld,
  output logic signed [AB-1:0]             ang_o,
  output logic signed [eqh_pkg::VEC_W-1:0] mag_o
);
  import eqh_pkg::*;

  localparam logic signed [AB-1:0] HALF = AB'(64'd1 << (AB - 1));

  logic                    vld_r  [0:NS];
  logic signed [VEC_W-1:0] x_r    [0:NS];
  logic signed [VEC_W-1:0] y_r    [0:NS];
  logic signed [AB-1:0]    z_r    [0:NS];
  logic                    zero_r [0:NS];

  // move the vector into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    zero_r[0] <= (x_i == 0) && (y_i == 0);
    if (x_i < 0) begin
      x_r[0] <= -x_i;
      y_r[0] <= -y_i;
      z_r[0] <= HALF;
    end else begin
      x_r[0] <= x_i;
      y_r[0] <= y_i;
      z_r[0] <= '0;
    end
  end

  // drive y toward zero, one step per stage
  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam logic signed [AB-1:0] ATN = AB'(atan_unit(AB, k - 1));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      if (y_r[k-1] < 0) begin
        x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k - 1));
        y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k - 1));
        z_r[k] <= z_r[k-1] - ATN;
      end else begin
        x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k - 1));
        y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k - 1));
        z_r[k] <= z_r[k-1] + ATN;
      end
      zero_r[k] <= zero_r[k-1];
    end
  end

  // a zero vector has angle zero
  assign out_vld = vld_r[NS];
  assign ang_o   = zero_r[NS] ? '0 : z_r[NS];
  assign mag_o   = x_r[NS];

endmodule
`default_nettype wire
